// ===== design/arsg_pkg.sv =====
// Package for the attitude/rate sample gate: codes, widths, beat types.
// No dependencies; used by the interfaces and every module.
package arsg_pkg;

   localparam int SeqWidthDefault = 32;

   localparam logic [1:0] ACT_ROT = 2'd0;
   localparam logic [1:0] ACT_GYRO = 2'd1;
   localparam logic [1:0] ACT_SAMPLE = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_REPEATED = 3'd2;
   localparam logic [2:0] ST_INCOMPLETE = 3'd3;
   localparam logic [2:0] ST_STALE = 3'd4;
   localparam logic [2:0] ST_SKEW = 3'd5;

   localparam logic [3:0] REG_MAX_AGE = 4'd0;
   localparam logic [3:0] REG_MAX_SKEW = 4'd4;
   localparam logic [3:0] REG_MIN_NORM = 4'd8;
   localparam logic [3:0] REG_MAX_NORM = 4'd12;

   localparam logic [31:0] MaxAgeReset = 32'd20000;
   localparam logic [31:0] MaxSkewReset = 32'd5000;
   localparam logic [30:0] MinNormReset = 31'd241591910;
   localparam logic [30:0] MaxNormReset = 31'd295279001;

   localparam logic [31:0] QOne = 32'h4000_0000;

   typedef struct packed {
      logic [1:0] action;
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      logic [7:0] report_accuracy;
      logic [63:0] time_us;
      logic signed [31:0] rate_x;
      logic signed [31:0] rate_y;
      logic signed [31:0] rate_z;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [31:0] sequence_number;
      logic [63:0] sample_time_us;
      logic signed [31:0] out_w;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_rate_x;
      logic signed [31:0] out_rate_y;
      logic signed [31:0] out_rate_z;
      logic [7:0] out_accuracy;
      logic sample_valid;
   } rsp_type;

   // Controller -> datapath commands
   typedef struct packed {
      logic load;        // capture request beat
      logic sq_step;     // accumulate one square (index in sq_idx)
      logic [1:0] sq_idx;
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;    // start divide of component div_idx
      logic div_step;
      logic [1:0] div_idx;
      logic div_store;   // write quotient to staging
      logic commit_rot;
      logic commit_gyro;
      logic dot_step;
      logic [1:0] dot_idx;
      logic emit;
      logic [2:0] status;
      logic rsp_load;
   } cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic [1:0] action;
      logic time_zero;
      logic rot_repeat;
      logic gyro_repeat;
      logic norm_bad;
      logic incomplete;
      logic stale;
      logic skew_bad;
   } stat_type;

endpackage

// ===== design/arsg_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on arsg_pkg.
interface arsg_req_if;
   import arsg_pkg::*;
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface arsg_rsp_if;
   import arsg_pkg::*;
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/arsg_ctrl.sv =====
// Sequencer for the sample gate: walks checks, squares, root, divides, dot products.
// Depends on arsg_pkg.
module arsg_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   input arsg_pkg::stat_type stat,
   output arsg_pkg::cmd_type cmd
);
   import arsg_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_SQ = 3'd2;
   localparam logic [2:0] S_SQRT = 3'd3;
   localparam logic [2:0] S_DIV = 3'd4;
   localparam logic [2:0] S_DOT = 3'd5;
   localparam logic [2:0] S_FIN = 3'd6;
   localparam logic [2:0] S_EMIT = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.sq_idx = idx_ff;
      cmd.div_idx = idx_ff;
      cmd.dot_idx = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            idx_in = 2'd0;
            cnt_in = '0;
            if (stat.action == ACT_ROT) begin
               if (stat.time_zero) begin
                  cmd.status = ST_INVALID;
                  state_in = S_FIN;
               end else if (stat.rot_repeat) begin
                  cmd.status = ST_REPEATED;
                  state_in = S_FIN;
               end else begin
                  state_in = S_SQ;
               end
            end else if (stat.action == ACT_GYRO) begin
               if (stat.time_zero) cmd.status = ST_INVALID;
               else if (stat.gyro_repeat) cmd.status = ST_REPEATED;
               else begin
                  cmd.status = ST_OK;
                  cmd.commit_gyro = 1'b1;
               end
               state_in = S_FIN;
            end else if (stat.action == ACT_SAMPLE) begin
               if (stat.incomplete) begin
                  cmd.status = ST_INCOMPLETE;
                  state_in = S_FIN;
               end else if (stat.stale) begin
                  cmd.status = ST_STALE;
                  state_in = S_FIN;
               end else if (stat.skew_bad) begin
                  cmd.status = ST_SKEW;
                  state_in = S_FIN;
               end else begin
                  state_in = S_DOT;
               end
            end else begin
               cmd.status = ST_INVALID;
               state_in = S_FIN;
            end
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) state_in = S_SQRT;
         end
         S_SQRT: begin
            if (cnt_ff == 6'd0) begin
               if (stat.norm_bad) begin
                  cmd.status = ST_INVALID;
                  state_in = S_FIN;
               end else begin
                  cmd.sqrt_init = 1'b1;
                  cnt_in = 6'd1;
               end
            end else begin
               cmd.sqrt_step = 1'b1;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd32) begin
                  cnt_in = '0;
                  idx_in = 2'd0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // per component: init, 32 quotient steps, store
            if (cnt_ff == 6'd0) begin
               cmd.div_init = 1'b1;
               cnt_in = 6'd1;
            end else if (cnt_ff <= 6'd32) begin
               cmd.div_step = 1'b1;
               cnt_in = cnt_ff + 6'd1;
            end else begin
               cmd.div_store = 1'b1;
               cnt_in = '0;
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  cmd.commit_rot = 1'b1;
                  cmd.status = ST_OK;
                  state_in = S_FIN;
               end
            end
         end
         S_DOT: begin
            cmd.dot_step = 1'b1;
            idx_in = idx_ff + 2'd1;
            if (idx_ff == 2'd3) state_in = S_EMIT;
         end
         S_EMIT: begin
            // last product is registered by now; fold it in and mark the sample
            cmd.emit = 1'b1;
            cmd.status = ST_OK;
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== design/arsg_dp.sv =====
// Datapath: stored state, norm accumulation, bit-serial root and divide, dot product.
// Depends on arsg_pkg.
module arsg_dp #(
   parameter int SEQUENCE_WIDTH = arsg_pkg::SeqWidthDefault
) (
   input logic clock,
   input logic reset,
   input arsg_pkg::req_type req,
   input arsg_pkg::cmd_type cmd,
   output arsg_pkg::stat_type stat,
   output arsg_pkg::rsp_type rsp,
   input logic [31:0] max_age_us,
   input logic [31:0] max_skew_us,
   input logic [30:0] min_norm,
   input logic [30:0] max_norm
);
   import arsg_pkg::*;

   req_type in_ff;
   logic [2:0] st_ff, st_in;

   logic signed [31:0] sq_ff [4];
   logic [7:0] acc_ff;
   logic [63:0] rot_t_ff;
   logic have_rot_ff;
   logic signed [31:0] rate_ff [3];
   logic [63:0] gyro_t_ff;
   logic have_gyro_ff;
   logic signed [31:0] last_ff [4];
   logic have_em_ff;
   logic [63:0] em_rot_ff, em_gyro_ff;
   logic [SEQUENCE_WIDTH-1:0] cnt_ff;

   // norm accumulator: 65 bits keeps the carry out of the four squares
   logic [64:0] sum_ff;
   logic [31:0] mag_sel;
   logic [63:0] sq_prod;
   logic signed [31:0] qsel;

   // square root registers
   logic [64:0] rem_ff;
   logic [63:0] root_ff, bit_ff;
   // divider registers
   logic [63:0] drem_ff;
   logic [31:0] quo_ff;
   logic [61:0] num_ff;
   logic signed [31:0] stage_ff [4];

   // dot product: one product per step
   logic signed [63:0] prod_ff;
   logic signed [65:0] dot_ff;
   logic dot_valid_ff;

   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      unique case (cmd.sq_idx)
         2'd0: qsel = in_ff.quat_w;
         2'd1: qsel = in_ff.quat_x;
         2'd2: qsel = in_ff.quat_y;
         default: qsel = in_ff.quat_z;
      endcase
   end
   assign mag_sel = qsel[31] ? 32'(-qsel) : qsel;
   assign sq_prod = mag_sel * mag_sel;

   logic [61:0] lo_sq, hi_sq;
   assign lo_sq = min_norm * min_norm;
   assign hi_sq = max_norm * max_norm;

   // time checks
   logic [63:0] age_r, age_g, skew;
   assign age_r = in_ff.time_us - rot_t_ff;
   assign age_g = in_ff.time_us - gyro_t_ff;
   assign skew = (rot_t_ff >= gyro_t_ff) ? rot_t_ff - gyro_t_ff : gyro_t_ff - rot_t_ff;

   always_comb begin
      stat.action = in_ff.action;
      stat.time_zero = (in_ff.time_us == 64'd0);
      stat.rot_repeat = have_rot_ff && (in_ff.time_us <= rot_t_ff);
      stat.gyro_repeat = have_gyro_ff && (in_ff.time_us <= gyro_t_ff);
      stat.norm_bad = sum_ff[64] || (sum_ff == 65'd0) || (sum_ff[63:0] < {2'b0, lo_sq})
         || (sum_ff[63:0] > {2'b0, hi_sq});
      stat.incomplete = !have_rot_ff || !have_gyro_ff || (rot_t_ff <= em_rot_ff)
         || (gyro_t_ff <= em_gyro_ff);
      stat.stale = (in_ff.time_us < rot_t_ff) || (in_ff.time_us < gyro_t_ff)
         || (age_r > {32'd0, max_age_us}) || (age_g > {32'd0, max_age_us});
      stat.skew_bad = skew > {32'd0, max_skew_us};
   end

   // root step: trial subtract of root+bit
   logic [64:0] trial;
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   // divide step: restoring, numerator shifted in MSB first
   logic [63:0] dshift;
   assign dshift = {drem_ff[62:0], num_ff[61]};

   logic signed [31:0] dsel_q;
   always_comb begin
      unique case (cmd.div_idx)
         2'd0: dsel_q = in_ff.quat_w;
         2'd1: dsel_q = in_ff.quat_x;
         2'd2: dsel_q = in_ff.quat_y;
         default: dsel_q = in_ff.quat_z;
      endcase
   end

   logic [31:0] dmag;
   assign dmag = dsel_q[31] ? 32'(-dsel_q) : dsel_q;
   // (mag<<30) + n/2
   logic [61:0] dnum;
   assign dnum = {dmag, 30'd0} + {1'b0, root_ff[61:1]};
   logic [31:0] qclamp;
   assign qclamp = (quo_ff > QOne) ? QOne : quo_ff;

   logic signed [31:0] q_out [4];
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_out[i] = (have_em_ff && dot_ff < 0) ? -sq_ff[i] : sq_ff[i];
      end
   end

   logic [SEQUENCE_WIDTH-1:0] cnt_next;
   assign cnt_next = cnt_ff + 1'b1;

   always_comb begin
      st_in = cmd.status;
   end

   // an emitted sample's beat carries the incremented count and the sign-followed quaternion
   always_comb begin
      rsp_in = '0;
      rsp_in.status = st_ff;
      if (dot_valid_ff) begin
         rsp_in.sequence_number = 32'(cnt_next);
         rsp_in.sample_time_us = (rot_t_ff >= gyro_t_ff) ? rot_t_ff : gyro_t_ff;
         rsp_in.out_w = q_out[0];
         rsp_in.out_x = q_out[1];
         rsp_in.out_y = q_out[2];
         rsp_in.out_z = q_out[3];
         rsp_in.out_rate_x = rate_ff[0];
         rsp_in.out_rate_y = rate_ff[1];
         rsp_in.out_rate_z = rate_ff[2];
         rsp_in.out_accuracy = acc_ff;
         rsp_in.sample_valid = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) in_ff <= req;
      if (cmd.load) sum_ff <= '0;
      if (cmd.sq_step) sum_ff <= sum_ff + {1'b0, sq_prod};
      if (cmd.sqrt_init) begin
         rem_ff <= sum_ff;
         root_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end
      if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.div_init) begin
         // quotient stays below 2^32, so the top 30 numerator bits are already
         // below n: preload them as the remainder, shift in the low 32
         num_ff <= {dnum[31:0], 30'd0};
         drem_ff <= {34'd0, dnum[61:32]};
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         if (dshift >= root_ff) begin
            drem_ff <= dshift - root_ff;
            quo_ff <= {quo_ff[30:0], 1'b1};
         end else begin
            drem_ff <= dshift;
            quo_ff <= {quo_ff[30:0], 1'b0};
         end
         num_ff <= {num_ff[60:0], 1'b0};
      end
      if (cmd.div_store) stage_ff[cmd.div_idx] <= dsel_q[31] ? -qclamp : qclamp;
      if (cmd.dot_step) prod_ff <= sq_ff[cmd.dot_idx] * last_ff[cmd.dot_idx];
      if (cmd.rsp_load) rsp_ff <= rsp_in;
      if (cmd.status != ST_OK || cmd.commit_rot || cmd.commit_gyro || cmd.emit) st_ff <= st_in;
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            sq_ff[i] <= '0;
            last_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) rate_ff[i] <= '0;
         acc_ff <= '0;
         rot_t_ff <= '0;
         have_rot_ff <= 1'b0;
         gyro_t_ff <= '0;
         have_gyro_ff <= 1'b0;
         have_em_ff <= 1'b0;
         em_rot_ff <= '0;
         em_gyro_ff <= '0;
         cnt_ff <= '0;
         dot_ff <= '0;
         dot_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            dot_ff <= '0;
            dot_valid_ff <= 1'b0;
         end
         // dot accumulates the product registered one step earlier
         if (cmd.dot_step && cmd.dot_idx != 2'd0) dot_ff <= dot_ff + 66'(prod_ff);
         if (cmd.commit_gyro) begin
            rate_ff[0] <= in_ff.rate_x;
            rate_ff[1] <= in_ff.rate_y;
            rate_ff[2] <= in_ff.rate_z;
            gyro_t_ff <= in_ff.time_us;
            have_gyro_ff <= 1'b1;
         end
         if (cmd.commit_rot) begin
            for (int i = 0; i < 3; i++) sq_ff[i] <= stage_ff[i];
            sq_ff[3] <= dsel_q[31] ? -qclamp : qclamp;
            acc_ff <= in_ff.report_accuracy;
            rot_t_ff <= in_ff.time_us;
            have_rot_ff <= 1'b1;
         end
         if (cmd.emit) begin
            // last product folds in here; sign decided in FIN
            dot_ff <= dot_ff + 66'(prod_ff);
            dot_valid_ff <= 1'b1;
         end
         if (dot_valid_ff && cmd.rsp_load) begin
            cnt_ff <= cnt_next;
            have_em_ff <= 1'b1;
            em_rot_ff <= rot_t_ff;
            em_gyro_ff <= gyro_t_ff;
            for (int i = 0; i < 4; i++) last_ff[i] <= q_out[i];
         end
      end
   end

   assign rsp = rsp_ff;
endmodule

// ===== design/attitude_rate_sample_gate.sv =====
// Attitude/rate sample gate top level; depends on arsg_pkg, arsg_if, arsg_ctrl, arsg_dp.
// From accept to result valid: rotation report (decide, 4 squares, root, 4 divides,
// finish); out-of-bounds norm (decide, 4 squares, root check, finish); emitted
// sample (decide, 4 products, sign fold, finish); gyro report or other refused item
// (decide, finish). One item in flight: next beat taken once idle and result taken.
// Synchronous active-high reset clears control and stored state and loads CSR defaults.
module attitude_rate_sample_gate #(
   parameter int SEQUENCE_WIDTH = arsg_pkg::SeqWidthDefault
) (
   input logic clock,
   input logic reset,
   arsg_req_if.sink req,
   arsg_rsp_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [3:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   import arsg_pkg::*;

   logic [31:0] max_age_ff, max_skew_ff;
   logic [30:0] min_norm_ff, max_norm_ff;
   cmd_type cmd;
   stat_type stat;
   rsp_type rsp_beat;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff <= MaxAgeReset;
         max_skew_ff <= MaxSkewReset;
         min_norm_ff <= MinNormReset;
         max_norm_ff <= MaxNormReset;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr)
            REG_MAX_AGE: max_age_ff <= csr_pwdata;
            REG_MAX_SKEW: max_skew_ff <= csr_pwdata;
            REG_MIN_NORM: min_norm_ff <= csr_pwdata[30:0];
            REG_MAX_NORM: max_norm_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         REG_MAX_AGE: csr_prdata = max_age_ff;
         REG_MAX_SKEW: csr_prdata = max_skew_ff;
         REG_MIN_NORM: csr_prdata = {1'b0, min_norm_ff};
         REG_MAX_NORM: csr_prdata = {1'b0, max_norm_ff};
         default: csr_prdata = '0;
      endcase
   end

   // sequencer valid rises with the load of the result register
   logic ctrl_rsp_valid;
   arsg_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .rsp_valid(ctrl_rsp_valid),
      .rsp_ready(rsp.ready),
      .stat(stat),
      .cmd(cmd)
   );

   arsg_dp #(.SEQUENCE_WIDTH(SEQUENCE_WIDTH)) u_dp (
      .clock(clock),
      .reset(reset),
      .req(req.payload),
      .cmd(cmd),
      .stat(stat),
      .rsp(rsp_beat),
      .max_age_us(max_age_ff),
      .max_skew_us(max_skew_ff),
      .min_norm(min_norm_ff),
      .max_norm(max_norm_ff)
   );

   // result register is written at the FIN edge, together with valid
   assign rsp.valid = ctrl_rsp_valid;
   assign rsp.payload = rsp_beat;
endmodule

// ===== bench/arsg_tb_if.sv =====
`timescale 1ns / 100ps
// Holds only the bench package (cycle limit); the bench uses the design's channel interfaces
// (arsg_req_if, arsg_rsp_if) from design/arsg_if.sv. Depends on arsg_pkg.
package arsg_tb_pkg;
   import arsg_pkg::*;
   localparam int CycleLimit = 2000000;
endpackage

// ===== bench/attitude_rate_sample_gate_tb.sv =====
`timescale 1ns / 100ps
// Bench for the attitude/rate sample gate: directed and random report and
// sample beats, APB register phases, in-bench predictor. Depends on arsg_pkg, arsg_if.
module attitude_rate_sample_gate_tb;
   import arsg_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   arsg_req_if req ();
   arsg_rsp_if rsp ();

   attitude_rate_sample_gate dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gate model state
   logic [31:0] age_limit, skew_limit;
   logic [30:0] norm_lo, norm_hi;
   logic signed [31:0] unit_q[4], prev_q[4], rates[3];
   logic [7:0] accuracy;
   logic [63:0] rot_t, gyro_t, used_rot_t, used_gyro_t;
   logic got_rot, got_gyro, emitted;
   logic [31:0] seq_count;

   req_type pending_beats[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   int cycles = 0;
   logic feeding = 1'b0;  // gate for the driver while the initial block sets up

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] magnitude(logic signed [31:0] v);
      return v < 0 ? 64'(-64'(v)) : 64'(v);
   endfunction

   function automatic logic [2:0] rotation_status(req_type b);
      logic [63:0] mag[4];
      logic [64:0] sum;
      logic [63:0] n, r;
      if (b.time_us == 0) return ST_INVALID;
      if (got_rot && b.time_us <= rot_t) return ST_REPEATED;
      sum = 0;
      mag[0] = magnitude(b.quat_w);
      mag[1] = magnitude(b.quat_x);
      mag[2] = magnitude(b.quat_y);
      mag[3] = magnitude(b.quat_z);
      for (int i = 0; i < 4; i++) sum = sum + 65'(mag[i] * mag[i]);
      // sum past 64 bits is above every limit
      if (sum[64] || sum == 0) return ST_INVALID;
      if (sum[63:0] < 64'(norm_lo) * 64'(norm_lo) ||
          sum[63:0] > 64'(norm_hi) * 64'(norm_hi)) return ST_INVALID;
      n = root64(sum[63:0]);
      for (int i = 0; i < 4; i++) begin
         r = ((mag[i] << 30) + (n >> 1)) / n;
         if (r > 64'(QOne)) r = 64'(QOne);
         unit_q[i] = (i == 0 ? b.quat_w : i == 1 ? b.quat_x : i == 2 ? b.quat_y : b.quat_z)
                     < 0 ? -32'(r) : 32'(r);
      end
      accuracy = b.report_accuracy;
      rot_t = b.time_us;
      got_rot = 1'b1;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_gate(req_type b);
      rsp_type o;
      logic signed [63:0] dot;
      logic [63:0] now, skew;
      o = '0;
      case (b.action)
         ACT_ROT: o.status = rotation_status(b);
         ACT_GYRO: begin
            if (b.time_us == 0) o.status = ST_INVALID;
            else if (got_gyro && b.time_us <= gyro_t) o.status = ST_REPEATED;
            else begin
               rates[0] = b.rate_x;
               rates[1] = b.rate_y;
               rates[2] = b.rate_z;
               gyro_t = b.time_us;
               got_gyro = 1'b1;
               o.status = ST_OK;
            end
         end
         ACT_SAMPLE: begin
            now = b.time_us;
            skew = rot_t >= gyro_t ? rot_t - gyro_t : gyro_t - rot_t;
            if (!got_rot || !got_gyro || rot_t <= used_rot_t || gyro_t <= used_gyro_t)
               o.status = ST_INCOMPLETE;
            else if (now < rot_t || now < gyro_t || now - rot_t > 64'(age_limit) ||
                     now - gyro_t > 64'(age_limit))
               o.status = ST_STALE;
            else if (skew > 64'(skew_limit))
               o.status = ST_SKEW;
            else begin
               dot = 0;
               for (int i = 0; i < 4; i++) dot = dot + 64'(unit_q[i]) * 64'(prev_q[i]);
               for (int i = 0; i < 4; i++)
                  prev_q[i] = (emitted && dot < 0) ? -unit_q[i] : unit_q[i];
               seq_count = seq_count + 1;
               o.status = ST_OK;
               o.sequence_number = seq_count;
               o.sample_time_us = rot_t >= gyro_t ? rot_t : gyro_t;
               o.out_w = prev_q[0];
               o.out_x = prev_q[1];
               o.out_y = prev_q[2];
               o.out_z = prev_q[3];
               o.out_rate_x = rates[0];
               o.out_rate_y = rates[1];
               o.out_rate_z = rates[2];
               o.out_accuracy = accuracy;
               o.sample_valid = 1'b1;
               emitted = 1'b1;
               used_rot_t = rot_t;
               used_gyro_t = gyro_t;
            end
         end
         default: o.status = ST_INVALID;
      endcase
      return o;
   endfunction

   // Driver: one beat at a time from pending_beats, random gap between beats
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.payload <= '0;
      end else if (req.valid && !req.ready) begin
         // hold the beat
      end else begin
         if (req.valid) expected_rsps.push_back(predict_gate(req.payload));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (feeding && pending_beats.size() > 0) begin
            req.payload <= pending_beats.pop_front();
            req.valid <= 1'b1;
            send_gap <= $urandom_range(0, 6);
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Monitor: random stall per beat, field check against the oldest expectation
   int take_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected beat, actual %p", $time, rsp.payload);
               errors++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e !== rsp.payload) begin
                  $display("%0t: mismatch, expected %p actual %p", $time, e, rsp.payload);
                  errors++;
               end
            end
            take_gap <= $urandom_range(0, 6);
            rsp.ready <= 1'b0;
         end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > arsg_tb_pkg::CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic csr_write(logic [3:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (addr)
         REG_MAX_AGE: age_limit = data;
         REG_MAX_SKEW: skew_limit = data;
         REG_MIN_NORM: norm_lo = data[30:0];
         REG_MAX_NORM: norm_hi = data[30:0];
         default: ;
      endcase
   endtask

   // Run queued beats and wait for the block to go idle
   task automatic run_phase();
      feeding = 1'b1;
      while (pending_beats.size() > 0 || req.valid || expected_rsps.size() > 0)
         @(posedge clock);
      feeding = 1'b0;
      repeat (250) @(posedge clock);
   endtask

   function automatic req_type beat_of(logic [1:0] act, logic [63:0] t);
      req_type b;
      b = '0;
      b.action = act;
      b.time_us = t;
      return b;
   endfunction

   logic [63:0] clock_us = 64'd1000;

   // A rotation report with a random quaternion of norm near one in Q3.28
   function automatic req_type rand_rotation(logic [63:0] t);
      req_type b;
      int k;
      b = beat_of(ACT_ROT, t);
      k = $urandom_range(0, 3);
      b.quat_w = $signed(32'($urandom_range(0, 200000000))) - 100000000;
      b.quat_x = $signed(32'($urandom_range(0, 200000000))) - 100000000;
      b.quat_y = $signed(32'($urandom_range(0, 200000000))) - 100000000;
      b.quat_z = $signed(32'($urandom_range(0, 200000000))) - 100000000;
      case (k)
         0: b.quat_w = $urandom_range(0, 1) ? 32'sd230000000 : -32'sd230000000;
         1: b.quat_x = $urandom_range(0, 1) ? 32'sd230000000 : -32'sd230000000;
         2: b.quat_y = $urandom_range(0, 1) ? 32'sd230000000 : -32'sd230000000;
         default: b.quat_z = $urandom_range(0, 1) ? 32'sd230000000 : -32'sd230000000;
      endcase
      b.report_accuracy = $urandom;
      return b;
   endfunction

   initial begin
      req_type b;
      age_limit = MaxAgeReset;
      skew_limit = MaxSkewReset;
      norm_lo = MinNormReset;
      norm_hi = MaxNormReset;
      foreach (unit_q[i]) begin
         unit_q[i] = 0;
         prev_q[i] = 0;
      end
      foreach (rates[i]) rates[i] = 0;
      accuracy = 0;
      rot_t = 0;
      gyro_t = 0;
      used_rot_t = 0;
      used_gyro_t = 0;
      got_rot = 0;
      got_gyro = 0;
      emitted = 0;
      seq_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: incomplete, zero times, unknown action, extremes, zero quaternion
      pending_beats.push_back(beat_of(ACT_SAMPLE, 64'd500));
      pending_beats.push_back(beat_of(ACT_ROT, 64'd0));
      pending_beats.push_back(beat_of(ACT_GYRO, 64'd0));
      b = beat_of(2'd3, '1);
      b.quat_w = '1;
      b.rate_x = '1;
      pending_beats.push_back(b);
      pending_beats.push_back(beat_of(ACT_ROT, 64'd10));  // zero quaternion
      b = beat_of(ACT_ROT, 64'd11);
      b.quat_w = 32'h8000_0000;
      b.quat_x = 32'h8000_0000;
      b.quat_y = 32'h8000_0000;
      b.quat_z = 32'h8000_0000;
      pending_beats.push_back(b);  // sum of squares overflows
      b = beat_of(ACT_ROT, 64'd12);
      b.quat_w = -32'sd268435456;
      b.report_accuracy = 8'hFF;
      pending_beats.push_back(b);
      pending_beats.push_back(beat_of(ACT_ROT, 64'd12));  // repeated
      b = beat_of(ACT_GYRO, 64'd13);
      b.rate_x = 32'h7FFF_FFFF;
      b.rate_y = 32'h8000_0000;
      b.rate_z = '1;
      pending_beats.push_back(b);
      pending_beats.push_back(beat_of(ACT_GYRO, 64'd13));
      pending_beats.push_back(beat_of(ACT_SAMPLE, 64'd5));         // stale: before
      pending_beats.push_back(beat_of(ACT_SAMPLE, 64'd100000));    // stale: old
      pending_beats.push_back(beat_of(ACT_SAMPLE, 64'd20));        // emitted
      pending_beats.push_back(beat_of(ACT_SAMPLE, 64'd21));        // not newer
      b = rand_rotation(64'd9000);
      pending_beats.push_back(b);
      pending_beats.push_back(beat_of(ACT_SAMPLE, 64'd9001));      // gyro not newer
      pending_beats.push_back(beat_of(ACT_GYRO, 64'd14));
      pending_beats.push_back(beat_of(ACT_SAMPLE, 64'd9001));      // skew
      run_phase();

      // Register extremes and inverted norm bounds
      csr_write(REG_MAX_AGE, 32'hFFFF_FFFF);
      csr_write(REG_MAX_SKEW, 32'hFFFF_FFFF);
      csr_write(REG_MIN_NORM, 32'h7FFF_FFFF);
      csr_write(REG_MAX_NORM, 32'd1);
      pending_beats.push_back(rand_rotation(64'd20000));
      b = beat_of(ACT_ROT, '1);
      b.quat_w = 32'h7FFF_FFFF;
      pending_beats.push_back(b);
      run_phase();
      csr_write(REG_MIN_NORM, 32'd1);
      csr_write(REG_MAX_NORM, 32'h7FFF_FFFF);
      b = beat_of(ACT_ROT, 64'd30000);
      b.quat_z = 32'sd1;
      pending_beats.push_back(b);
      b = beat_of(ACT_ROT, 64'hFFFF_FFFF_FFFF_FFFE);
      b.quat_w = 32'h8000_0000;
      b.quat_y = 32'h7FFF_FFFF;
      pending_beats.push_back(b);
      pending_beats.push_back(beat_of(ACT_SAMPLE, '1));
      run_phase();

      // Random phases with modest limits; top-of-range gyro stamp waits for the end
      for (int phase = 0; phase < 4; phase++) begin
         csr_write(REG_MAX_AGE, phase == 3 ? 32'd1 : $urandom_range(2000, 40000));
         csr_write(REG_MAX_SKEW, phase == 3 ? 32'd1 : $urandom_range(500, 8000));
         csr_write(REG_MIN_NORM, MinNormReset);
         csr_write(REG_MAX_NORM, phase == 2 ? MinNormReset - 1 : MaxNormReset);
         for (int n = 0; n < 160; n++) begin
            int pick;
            pick = $urandom_range(0, 9);
            clock_us = clock_us + $urandom_range(1, 3000);
            if (pick < 4) pending_beats.push_back(rand_rotation(clock_us));
            else if (pick < 7) begin
               b = beat_of(ACT_GYRO, clock_us);
               b.rate_x = $urandom;
               b.rate_y = $urandom;
               b.rate_z = $urandom;
               pending_beats.push_back(b);
            end else if (pick < 9) begin
               pending_beats.push_back(beat_of(ACT_SAMPLE, clock_us + $urandom_range(0, 3000)));
            end else begin
               b = '0;
               b.action = $urandom;
               b.quat_w = $urandom;
               b.quat_x = $urandom;
               b.quat_y = $urandom;
               b.quat_z = $urandom;
               b.report_accuracy = $urandom;
               b.time_us = {$urandom, $urandom};
               if ($urandom_range(0, 1)) b.time_us = clock_us - $urandom_range(0, 5000);
               pending_beats.push_back(b);
            end
         end
         run_phase();
      end

      pending_beats.push_back(beat_of(ACT_GYRO, '1));
      pending_beats.push_back(beat_of(ACT_SAMPLE, '1));
      run_phase();

      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== attitude_rate_sample_gate.f =====
design/arsg_pkg.sv
design/arsg_if.sv
design/arsg_ctrl.sv
design/arsg_dp.sv
design/attitude_rate_sample_gate.sv
bench/arsg_tb_if.sv
bench/attitude_rate_sample_gate_tb.sv
